>>> hw/rtl/qsi_pkg.sv
// Shared types and constants for the queue with sorted insert.
package qsi_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        kind;
    logic signed [DATA_W-1:0]   value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   popped_value;
    logic                       pop_on_empty;
    logic                       overflow;
    logic signed [DATA_W-1:0]   front_value;
    logic                       is_empty;
    logic [COUNT_W-1:0]         entry_count;
  } out_t;

  // Broadcast command seen by every cell in the row.
  typedef struct packed {
    logic                       en;
    op_t                        op;
    logic signed [DATA_W-1:0]   value;
    logic                       full;
  } cell_cmd_t;

endpackage

>>> hw/rtl/queue_with_sorted_insert.sv
// Queue with sorted insert: a row of DEPTH cells that shift in lockstep.
//
// Bounded queue of signed 32-bit values held in a row of DEPTH identical cells,
// cell 0 being the front. Each input transfer carries one operation: push at the
// rear, pop from the front, sorted insert, or clear. Every cell sees the command
// at once; a pop shifts every cell one place toward the front, a push loads the
// cell at the tail, and a sorted insert lets each cell compare its value against
// the new one, so the cells in front of the insertion point keep their values,
// the insertion cell loads the new value and the cells behind it take their
// left neighbor's value. The "all in front are smaller" flag ripples from cell 0
// down the row, which is the longest path. One operation completes per clock
// unless the output stalls: the queue state updates at the edge that accepts
// the transfer, and its result sits in an output register the cycle after.
// in_ready is high whenever that register is empty or is being drained, so
// back-to-back transfers run at one item per cycle. A full queue refuses push
// and insert (overflow flag); an empty queue pops 0 with pop_on_empty.
// Slot contents are not cleared by reset or clear; only the count is.
module queue_with_sorted_insert
  import qsi_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  out_t                     out_r;
  out_t                     out_nxt;
  logic                     accept;
  logic                     full;
  logic                     empty;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] slot_val [DEPTH];
  logic signed [DATA_W-1:0] slot_nxt_val [DEPTH];
  logic                     lt_chain [DEPTH+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign cmd.en    = accept;
  assign cmd.op    = in_data.kind;
  assign cmd.value = in_data.value;
  assign cmd.full  = full;

  // insertion point search starts true in front of cell 0
  assign lt_chain[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;

    if (i == 0) begin : g_front
      assign left_v = in_data.value;
    end else begin : g_mid_l
      assign left_v = slot_val[i-1];
    end

    // the rear cell takes its own value on a pop; it falls outside the count
    if (i == DEPTH - 1) begin : g_rear
      assign right_v = slot_val[i];
    end else begin : g_mid_r
      assign right_v = slot_val[i+1];
    end

    qsi_cell u_cell (
      .clk            (clk),
      .cmd            (cmd),
      .occupied       (CNT_W'(i) < count_r),
      .at_tail        (CNT_W'(i) == count_r),
      .left_value     (left_v),
      .right_value    (right_v),
      .lt_chain_in    (lt_chain[i]),
      .lt_chain_out   (lt_chain[i+1]),
      .slot_value     (slot_val[i]),
      .slot_nxt_value (slot_nxt_val[i])
    );
  end

  // count update and result assembly
  always_comb begin
    count_nxt            = count_r;
    out_nxt              = out_r;
    out_valid_nxt        = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (accept) begin
      out_nxt.popped_value = '0;
      out_nxt.pop_on_empty = 1'b0;
      out_nxt.overflow     = 1'b0;
      case (in_data.kind)
        OP_PUSH, OP_INSERT: begin
          if (full) out_nxt.overflow = 1'b1;
          else      count_nxt = count_r + CNT_W'(1);
        end
        OP_POP: begin
          if (empty) begin
            out_nxt.pop_on_empty = 1'b1;
          end else begin
            out_nxt.popped_value = slot_val[0];
            count_nxt            = count_r - CNT_W'(1);
          end
        end
        default: begin
          count_nxt = '0;
        end
      endcase
      out_nxt.is_empty    = (count_nxt == '0);
      out_nxt.front_value = (count_nxt == '0) ? '0 : slot_nxt_val[0];
      out_nxt.entry_count = COUNT_W'(count_nxt);
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  // a refused push or insert leaves a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overflow) |-> (out_r.entry_count == COUNT_W'(DEPTH)))
    else $error("overflow reported on a queue that is not full");

  // a pop on empty reports an empty queue with no value
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.pop_on_empty) |->
      (out_r.is_empty && out_r.popped_value == '0))
    else $error("pop on empty with a non-empty result");

  // a clear transfer yields an empty queue
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind == OP_CLEAR) |=> (out_valid_r && out_r.is_empty && count_r == '0))
    else $error("clear did not empty the queue");

endmodule

>>> hw/rtl/qsi_cell.sv
// One slot of the queue: holds a value and shifts, keeps or loads per command.
module qsi_cell
  import qsi_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic                     occupied,
  input  logic                     at_tail,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  input  logic                     lt_chain_in,
  output logic                     lt_chain_out,
  output logic signed [DATA_W-1:0] slot_value,
  output logic signed [DATA_W-1:0] slot_nxt_value
);

  logic signed [DATA_W-1:0] slot_r;
  logic signed [DATA_W-1:0] slot_nxt;
  logic                     lt_here;

  // all slots in front of and including this one are below the new value
  assign lt_here      = occupied && (slot_r < cmd.value);
  assign lt_chain_out = lt_chain_in && lt_here;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.en) begin
      case (cmd.op)
        OP_PUSH: begin
          if (!cmd.full && at_tail) slot_nxt = cmd.value;
        end
        OP_POP: begin
          slot_nxt = right_value;
        end
        OP_INSERT: begin
          if (!cmd.full && !lt_chain_out) begin
            if (lt_chain_in) slot_nxt = cmd.value;
            else             slot_nxt = left_value;
          end
        end
        default: begin
          slot_nxt = slot_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_value     = slot_r;
  assign slot_nxt_value = slot_nxt;

endmodule
